/* src/raycast_wall_column_texturer_assert.svh */
// Assertion macros used by the wall column texturer top level.
// Depends on nothing; included by the top level, which checks itself.
`ifndef RAYCAST_WALL_COLUMN_TEXTURER_ASSERT_SVH
`define RAYCAST_WALL_COLUMN_TEXTURER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define RCWT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RCWT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/rcwt_pkg.sv */
// Shared types and constants of the wall column texturer.
// Used by the divider and the top level.
package rcwt_pkg;

   localparam int SCREEN_HEIGHT = 480;
   localparam int HALF_SCREEN   = SCREEN_HEIGHT / 2;
   localparam int TEX_WIDTH     = 64;
   localparam int TEX_HEIGHT    = 64;
   localparam int TEX_W_BITS    = $clog2(TEX_WIDTH);
   localparam int TEX_H_BITS    = $clog2(TEX_HEIGHT);
   localparam int MAP_BITS      = 12;
   localparam int MAP_COUNT     = 4;
   localparam int STORE_DEPTH   = MAP_COUNT * (1 << MAP_BITS);
   localparam int COLOR_W       = 24;
   localparam int ROW_W         = 9;
   localparam int COL_W         = 10;
   localparam int LH_W          = 16;
   localparam int STEP_W        = 24;
   localparam int N_W           = 17;

   localparam logic [COLOR_W-1:0] SHADE_MASK = 24'h7F7F7F;

   // Divider sizes: numerator holds SCREEN_HEIGHT << 16, divisor a distance.
   localparam int DIV_NUM_W = 25;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   localparam logic [DIV_NUM_W-1:0] LH_NUM   = DIV_NUM_W'(SCREEN_HEIGHT) << 16;
   localparam logic [DIV_NUM_W-1:0] STEP_NUM = DIV_NUM_W'(TEX_HEIGHT) << 16;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_SETUP = 2'd1;
   localparam logic [1:0] FUNC_ROW   = 2'd2;

   localparam logic CSR_CEILING = 1'b0;
   localparam logic CSR_FLOOR   = 1'b1;

   typedef struct packed {
      logic [1:0]          pad;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    column;
      logic [23:0]         pos_y;
      logic [23:0]         pos_x;
      logic                hit_side;
      logic signed [17:0]  ray_dir_y;
      logic signed [17:0]  ray_dir_x;
      logic [23:0]         wall_dist;
      logic [COLOR_W-1:0]  texel_color;
      logic [MAP_BITS-1:0] texel_addr;
      logic [1:0]          tex_select;
   } req_data_type;

   typedef struct packed {
      logic [4:0]         pad;
      logic [COL_W-1:0]   out_column;
      logic [ROW_W-1:0]   out_row;
      logic [COLOR_W-1:0] pixel_color;
   } rsp_data_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_ROW_MUL  = 8'b0000_0010,
      S_ROW_RD   = 8'b0000_0100,
      S_ROW_OUT  = 8'b0000_1000,
      S_SET_MUL  = 8'b0001_0000,
      S_SET_FRAC = 8'b0010_0000,
      S_DIV_LH   = 8'b0100_0000,
      S_DIV_ST   = 8'b1000_0000
   } state_type;

endpackage

/* src/raycast_wall_column_texturer.sv */
// Top level of the wall column texturer: control sequencer, column state,
// texture RAM and setup divider. Depends on rcwt_pkg, rcwt_ram, rcwt_div.
//
// Usage: words enter on the req_ channel, tuser carrying the function code.
// A texel write stores one 24-bit texel in one of four 64x64 texture maps.
// A column setup latches wall height, draw span, face, texture column,
// shading and row step; height, then row step, come from two passes
// through the one-bit-per-cycle divider. A row request yields one word on
// the rsp_ channel: multiply, texture RAM read, then the output register
// loaded from RAM data. One item is in work at a time; a new request is
// taken only in the idle state. The output register lets the next request
// enter while a result waits; if rsp_tready stays low, the following row
// request holds in its last step until the register frees. Function
// code 3 is dropped. Reset clears the column state to a one-pixel wall at
// face 0 and empties the output register; texture contents are undefined
// until written. The user must write the ceiling and floor colors on the
// csr_ port only while idle; the block itself does not enforce it.
module raycast_wall_column_texturer
   import rcwt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // tex_select, texel_addr, texel_color, wall_dist, ray_dir_x, ray_dir_y,
   // hit_side, pos_x, pos_y, column, row, zero fill
   input  logic [167:0]        req_tdata,
   // func
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // pixel_color, out_row, out_column, zero fill
   output logic [47:0]         rsp_tdata,
   input  logic                csr_we,
   input  logic                csr_addr,
   input  logic [COLOR_W-1:0]  csr_wdata
);

`include "raycast_wall_column_texturer_assert.svh"

   localparam int SADDR_W = $clog2(STORE_DEPTH);

   req_data_type req;
   state_type    state_ff, state_in;
   logic         accept;

   logic [COLOR_W-1:0] ceil_ff, floor_ff;

   // latched setup operands
   logic [23:0]        dist_ff, px_ff, py_ff;
   logic signed [17:0] dx_ff, dy_ff;
   logic               side_in_ff;
   logic [COL_W-1:0]   col_in_ff;
   logic [41:0]        hmul_ff;

   // column state
   logic [LH_W-1:0]       lh_ff, lh_in;
   logic [ROW_W-1:0]      top_ff, top_in, bot_ff, bot_in;
   logic [1:0]            face_ff;
   logic [TEX_W_BITS-1:0] tx_ff;
   logic                  shade_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [COL_W-1:0]      cur_col_ff;

   // row request path
   logic [ROW_W-1:0]  row_ff;
   logic [40:0]       rmul_ff;
   logic              is_ceil_ff, is_floor_ff;

   logic                  rsp_valid_ff;
   rsp_data_type          rsp_ff;
   logic                  rsp_load;

   logic                  ram_we, ram_re;
   logic [SADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [COLOR_W-1:0]    ram_rdata, texel;

   logic                  div_start;
   logic [DIV_NUM_W-1:0]  div_num, div_quot;
   logic [DIV_DEN_W-1:0]  div_den;
   div_stat_type          div_stat;

   logic                  dir_neg;
   logic [17:0]           dir_sel, dir_mag;
   logic [23:0]           pos_sel;
   logic [31:0]           frac;
   logic                  dx_pos, dx_neg, dy_pos, dy_neg;
   logic [LH_W-2:0]       half;
   logic [N_W-1:0]        n_val;
   logic [TEX_H_BITS-1:0] ty;
   logic [MAP_BITS-1:0]   taddr;

   assign req        = req_data_type'(req_tdata);
   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;

   assign dx_pos = !dx_ff[17] && (dx_ff != '0);
   assign dx_neg = dx_ff[17];
   assign dy_pos = !dy_ff[17] && (dy_ff != '0);
   assign dy_neg = dy_ff[17];

   always_comb begin
      dir_sel = side_in_ff ? dx_ff : dy_ff;
      pos_sel = side_in_ff ? px_ff : py_ff;
      dir_neg = dir_sel[17];
      dir_mag = dir_neg ? 18'(~dir_sel + 18'd1) : dir_sel;
      frac    = dir_neg ? ({pos_sel[15:0], 16'b0} - hmul_ff[31:0])
                        : ({pos_sel[15:0], 16'b0} + hmul_ff[31:0]);
   end

   // height and span from the first quotient
   always_comb begin
      if (div_quot > DIV_NUM_W'(16'hFFFF)) begin
         lh_in = 16'hFFFF;
      end else if (div_quot == '0) begin
         lh_in = LH_W'(1);
      end else begin
         lh_in = div_quot[LH_W-1:0];
      end
      half   = lh_in[LH_W-1:1];
      top_in = (half > (LH_W-1)'(HALF_SCREEN)) ? '0
               : ROW_W'((LH_W-1)'(HALF_SCREEN) - half);
      bot_in = ((LH_W'(HALF_SCREEN) + LH_W'(half)) >= LH_W'(SCREEN_HEIGHT))
               ? ROW_W'(SCREEN_HEIGHT - 1)
               : ROW_W'(LH_W'(HALF_SCREEN) + LH_W'(half));
   end

   always_comb begin
      n_val = N_W'(row_ff) + N_W'(lh_ff[LH_W-1:1]) - N_W'(HALF_SCREEN);
      ty    = rmul_ff[16 +: TEX_H_BITS];
      taddr = MAP_BITS'((MAP_BITS'(ty) << TEX_H_BITS) + MAP_BITS'(tx_ff));
      texel = shade_ff ? ((ram_rdata >> 1) & SHADE_MASK) : ram_rdata;
   end

   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      div_num   = LH_NUM;
      div_den   = dist_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_tuser == FUNC_SETUP) begin
               state_in = S_SET_MUL;
            end else if (accept && req_tuser == FUNC_ROW) begin
               state_in = S_ROW_MUL;
            end
         end
         S_ROW_MUL:  state_in = S_ROW_RD;
         S_ROW_RD:   state_in = S_ROW_OUT;
         S_ROW_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SET_MUL:  state_in = S_SET_FRAC;
         S_SET_FRAC: begin
            div_start = 1'b1;
            state_in  = S_DIV_LH;
         end
         S_DIV_LH: begin
            if (div_stat.done) begin
               div_start = 1'b1;
               div_num   = STEP_NUM;
               div_den   = DIV_DEN_W'(lh_in);
               state_in  = S_DIV_ST;
            end
         end
         S_DIV_ST: begin
            if (div_stat.done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ceil_ff      <= '0;
         floor_ff     <= '0;
         lh_ff        <= LH_W'(1);
         top_ff       <= '0;
         bot_ff       <= '0;
         face_ff      <= '0;
         tx_ff        <= '0;
         shade_ff     <= 1'b0;
         step_ff      <= '0;
         cur_col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && csr_addr == CSR_CEILING) begin
            ceil_ff <= csr_wdata;
         end
         if (csr_we && csr_addr == CSR_FLOOR) begin
            floor_ff <= csr_wdata;
         end
         if (state_ff == S_SET_FRAC) begin
            if (!side_in_ff && dx_pos) begin
               face_ff <= 2'd0;
            end else if (!side_in_ff && dx_neg) begin
               face_ff <= 2'd1;
            end else if (side_in_ff && dy_pos) begin
               face_ff <= 2'd2;
            end else begin
               face_ff <= 2'd3;
            end
            // mirror the column where the face is seen from behind
            tx_ff <= ((!side_in_ff && dx_pos) || (side_in_ff && dy_neg))
                     ? ~frac[31 -: TEX_W_BITS] : frac[31 -: TEX_W_BITS];
            shade_ff   <= side_in_ff;
            cur_col_ff <= col_in_ff;
         end
         if (state_ff == S_DIV_LH && div_stat.done) begin
            lh_ff  <= lh_in;
            top_ff <= top_in;
            bot_ff <= bot_in;
         end
         if (state_ff == S_DIV_ST && div_stat.done) begin
            step_ff <= div_quot[DIV_NUM_W-1:STEP_W] != '0 ? '1 : div_quot[STEP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dist_ff    <= req.wall_dist;
         dx_ff      <= req.ray_dir_x;
         dy_ff      <= req.ray_dir_y;
         side_in_ff <= req.hit_side;
         px_ff      <= req.pos_x;
         py_ff      <= req.pos_y;
         col_in_ff  <= req.column;
         row_ff     <= req.row;
      end
      if (state_ff == S_SET_MUL) begin
         hmul_ff <= 42'(dist_ff * dir_mag);
      end
      if (state_ff == S_ROW_MUL) begin
         rmul_ff     <= 41'(n_val * step_ff);
         is_ceil_ff  <= row_ff < top_ff;
         is_floor_ff <= row_ff > bot_ff;
      end
      if (rsp_load) begin
         rsp_ff.pad         <= '0;
         rsp_ff.out_row     <= row_ff;
         rsp_ff.out_column  <= cur_col_ff;
         rsp_ff.pixel_color <= is_ceil_ff ? ceil_ff : (is_floor_ff ? floor_ff : texel);
      end
   end

   assign ram_we    = accept && req_tuser == FUNC_WRITE;
   assign ram_waddr = {req.tex_select, req.texel_addr};
   assign ram_re    = state_ff == S_ROW_RD;
   assign ram_raddr = {face_ff, taddr};

   rcwt_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(STORE_DEPTH)
   ) u_tex_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(req.texel_color),
      .re(ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   rcwt_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(div_den),
      .quot(div_quot),
      .stat(div_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   `RCWT_ASSERT(a_lh_nonzero, clock, reset, lh_ff != '0, "line height reached zero")
   `RCWT_ASSERT(a_span_order, clock, reset, top_ff <= bot_ff, "draw span inverted")
   `RCWT_ASSERT(a_ram_excl, clock, reset, !(ram_we && ram_re), "texture read and write overlap")
   `RCWT_ASSERT(a_rd_then_out, clock, reset, (state_ff == S_ROW_RD) |=> (state_ff == S_ROW_OUT),
      "texture read not followed by output step")
   `RCWT_ASSERT(a_div_idle, clock, reset, div_stat.busy |-> (state_ff == S_DIV_LH || state_ff == S_DIV_ST),
      "divider busy outside setup")

endmodule

/* src/rcwt_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module rcwt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/rcwt_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on rcwt_pkg.
module rcwt_div
   import rcwt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_NUM_W-1:0] quot,
   output div_stat_type         stat
);

   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits   = trial >= {1'b0, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next numerator bit, subtract where it fits
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot      = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
